// ===== rtl/assert_macros.svh =====
// assertion helpers, sampled on clk_i with rst_ni low as disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/crlf_pkg.sv =====
`default_nettype none

package crlf_pkg;

  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_LONG  = 2'd2
  } kind_e;

endpackage

`default_nettype wire

// ===== rtl/crlf_if.sv =====
`default_nettype none

interface crlf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crlf_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output kind, output char_out, output last, input ready);
  modport sink (input valid, input kind, input char_out, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/crlf_store.sv =====
`default_nettype none

module crlf_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [IW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [IW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/crlf_line_assembler.sv =====
// Line assembler for a received byte stream. Line characters are written
// into a single-port-per-side line store of LINE_BYTES entries; CR, LF or
// CR LF ends a line (an LF right after a CR terminator is dropped, also
// across read chunks). An empty line, or one of LINE_BYTES characters or
// more, gives one result. A shorter line is played out from the store,
// each result by a store read (ST_RD) and then an output load (ST_OUT,
// which waits for a free output register); no byte is taken during
// playout. Results leave through a one-entry output register; a byte
// that needs no result is taken while a result waits. The store needs
// no clearing after reset: playout reads only entries of the current
// line.
`default_nettype none

`include "assert_macros.svh"

module crlf_line_assembler #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  crlf_byte_if.sink rx_i,
  crlf_res_if.source res_o
);
  import crlf_pkg::*;

  localparam int unsigned CW = $clog2(LINE_BYTES + 1);
  localparam int unsigned IW = $clog2(LINE_BYTES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] len_q, len_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          after_cr_q, after_cr_d;

  logic          ov_q, ov_d;
  kind_e         kind_q, kind_d;
  logic [7:0]    char_q, char_d;
  logic          last_q, last_d;

  logic          out_free;
  logic          is_cr, is_lf, is_term;
  logic          in_xfer;
  logic          we, re;
  logic [7:0]    rdata;
  logic          last_char;

  assign out_free  = !ov_q || res_o.ready;
  assign is_cr     = (rx_i.rx_byte == BYTE_CR);
  assign is_lf     = (rx_i.rx_byte == BYTE_LF);
  assign is_term   = is_cr || is_lf;
  assign last_char = ((CW'(idx_q) + CW'(1)) == len_q);

  // terminator waits for a free output register unless it is an LF dropped after a CR
  assign rx_i.ready = (state_q == ST_IDLE) && (out_free || !is_term || (is_lf && after_cr_q));
  assign in_xfer    = rx_i.valid && rx_i.ready;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    idx_d      = idx_q;
    after_cr_d = after_cr_q;
    ov_d       = res_o.ready ? 1'b0 : ov_q;
    kind_d     = kind_q;
    char_d     = char_q;
    last_d     = last_q;
    we         = 1'b0;
    re         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_lf && after_cr_q) begin
            after_cr_d = 1'b0;
          end else if (is_term) begin
            after_cr_d = is_cr;
            cnt_d      = '0;
            if (cnt_q == '0) begin
              ov_d   = 1'b1;
              kind_d = KIND_EMPTY;
              char_d = 8'd0;
              last_d = 1'b1;
            end else if (cnt_q >= CW'(LINE_BYTES)) begin
              ov_d   = 1'b1;
              kind_d = KIND_LONG;
              char_d = 8'd0;
              last_d = 1'b1;
            end else begin
              len_d   = cnt_q;
              idx_d   = '0;
              state_d = ST_RD;
            end
          end else begin
            after_cr_d = 1'b0;
            if (cnt_q < CW'(LINE_BYTES)) begin
              we    = 1'b1;
              cnt_d = cnt_q + CW'(1);
            end
          end
        end
      end
      ST_RD: begin
        re      = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          kind_d = KIND_CHAR;
          char_d = rdata;
          last_d = last_char;
          idx_d  = idx_q + IW'(1);
          state_d = last_char ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      after_cr_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      after_cr_q <= after_cr_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    idx_q  <= idx_d;
    kind_q <= kind_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  crlf_store #(
    .DEPTH (LINE_BYTES),
    .IW    (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (rx_i.rx_byte),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign res_o.valid    = ov_q;
  assign res_o.kind     = kind_q;
  assign res_o.char_out = char_q;
  assign res_o.last     = last_q;

  `ASSERT_AT(a_no_rx_in_playout, (state_q != ST_IDLE) |-> !rx_i.ready, "byte taken in playout")
  `ASSERT_AT(a_cnt_sat, cnt_q <= CW'(LINE_BYTES), "char count beyond line size")
  `ASSERT_AT(a_idx_in_line, (state_q != ST_IDLE) |-> (CW'(idx_q) < len_q), "playout past line")
  `ASSERT_IMPL(a_term_clears, in_xfer && is_term, cnt_q == '0, "count kept after terminator")

endmodule

`default_nettype wire
